FILE: rtl/core/sfoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfoc_pkg
// Shared types and constants of the stereo FIFO output format converter.
// ----------------------------------------------------------------------------
package sfoc_pkg;

   localparam int RING_FRAMES  = 8192;
   localparam int ADDR_W       = $clog2(RING_FRAMES);
   localparam int MAX_CHANNELS = 32;
   localparam int CH_W         = 5;
   localparam int FREE_W       = 13;
   localparam int CNT_W        = 6;
   localparam int FMT_W        = 3;
   localparam int SAMPLE_W     = 32;
   localparam int WORD_W       = 64;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic REG_CHANNEL_COUNT = 1'b0;
   localparam logic REG_SAMPLE_FORMAT = 1'b1;

   localparam logic [FMT_W-1:0] FMT_INT16   = 3'd0;
   localparam logic [FMT_W-1:0] FMT_INT24   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_INT32   = 3'd2;
   localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_FLOAT64 = 3'd4;

   localparam logic [30:0] SCALE_INT16 = 31'd32767;
   localparam logic [30:0] SCALE_INT24 = 31'd8388607;
   localparam logic [30:0] SCALE_INT32 = 31'h7FFF_FFFF;

   localparam logic [7:0]  F32_BIAS_Q = 8'd99;
   localparam logic [10:0] F64_BIAS_Q = 11'd995;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV_L,
      ST_CONV_R,
      ST_FINISH,
      ST_EMIT
   } sfoc_state_type;

   typedef struct packed {
      logic push;
      logic pull;
      logic sel_right;
      logic cap_l;
      logic cap_r;
      logic emit;
   } sfoc_cmd_type;

   typedef struct packed {
      logic ch_last;
   } sfoc_status_type;

endpackage

FILE: rtl/core/sfoc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfoc_ctrl
// Sequencer: accepts items, steps the converter and drives the result valid.
// ----------------------------------------------------------------------------
module sfoc_ctrl import sfoc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_func,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sfoc_cmd_type    cmd,
   input  sfoc_status_type status
);

   sfoc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (req_func) begin
                  cmd.pull = 1'b1;
                  state_in = ST_CONV_L;
               end else begin
                  cmd.push     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_CONV_L: begin
            state_in = ST_CONV_R;
         end
         ST_CONV_R: begin
            cmd.sel_right = 1'b1;
            cmd.cap_l     = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.cap_r = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.ch_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("req_ready outside idle");

   a_pull_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func) |=> state_ff == ST_CONV_L)
      else $error("pull did not start conversion");

   a_emit_loads_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted item not marked valid");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.ch_last && out_free) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after last channel");

endmodule

FILE: rtl/core/sfoc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfoc_dp
// Datapath: frame ring, indices, config registers, sample converter, result.
// ----------------------------------------------------------------------------
module sfoc_dp import sfoc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  sfoc_cmd_type           cmd,
   output sfoc_status_type        status,
   input  logic signed [31:0]     req_left_sample,
   input  logic signed [31:0]     req_right_sample,
   output logic                   rsp_accepted,
   output logic [FREE_W-1:0]      rsp_frames_free,
   output logic [CH_W-1:0]        rsp_channel,
   output logic [WORD_W-1:0]      rsp_sample_word,
   output logic                   rsp_underrun,
   output logic                   rsp_last,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata
);

   logic [2*SAMPLE_W-1:0] mem [RING_FRAMES];
   logic [2*SAMPLE_W-1:0] rdata_ff;

   logic [ADDR_W-1:0] wr_ff, wr_in;
   logic [ADDR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FMT_W-1:0]  fmt_ff, fmt_in;

   logic [ADDR_W-1:0] used;
   logic [ADDR_W-1:0] free_now;
   logic              full;
   logic              empty;
   logic [CH_W-1:0]   last_ch;
   logic              cfg_wr;

   logic [FREE_W-1:0] free_ff;
   logic              under_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [CH_W-1:0]   last_ch_ff;

   logic [SAMPLE_W-1:0] raw;
   logic                neg;
   logic [SAMPLE_W-1:0] mag;
   logic [30:0]         scale;
   logic [4:0]          top;

   logic                s1_neg_ff;
   logic [SAMPLE_W-1:0] s1_mag_ff;
   logic [62:0]         s1_prod_ff;
   logic [4:0]          s1_top_ff;

   logic [34:0]       q;
   logic [34:0]       q_lim;
   logic [34:0]       q_sat;
   logic [WORD_W-1:0] int_word;
   logic [31:0]       norm;
   logic              rnd;
   logic [24:0]       rsum;
   logic [7:0]        exp8;
   logic [10:0]       exp11;
   logic [WORD_W-1:0] conv_word;

   logic [WORD_W-1:0] conv_l_ff;
   logic [WORD_W-1:0] conv_r_ff;
   logic [WORD_W-1:0] emit_word;

   // ring occupancy
   assign used     = wr_ff - rd_ff;
   assign free_now = ADDR_W'(RING_FRAMES - 1) - used;
   assign full     = (free_now == '0);
   assign empty    = (used == '0);

   always_comb begin
      if (cnt_ff == '0) begin
         last_ch = '0;
      end else if (cnt_ff > CNT_W'(MAX_CHANNELS)) begin
         last_ch = CH_W'(MAX_CHANNELS - 1);
      end else begin
         last_ch = CH_W'(cnt_ff - 1'b1);
      end
   end

   assign status.ch_last = (ch_ff == last_ch_ff);

   // configuration port
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cnt_in = cnt_ff;
      fmt_in = fmt_ff;
      if (cfg_wr) begin
         case (csr_paddr[2])
            REG_CHANNEL_COUNT: cnt_in = csr_pwdata[CNT_W-1:0];
            REG_SAMPLE_FORMAT: fmt_in = csr_pwdata[FMT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CHANNEL_COUNT: csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cnt_ff};
         REG_SAMPLE_FORMAT: csr_prdata = {{(CSR_DATA_W-FMT_W){1'b0}}, fmt_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // indices
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (cmd.push && !full) begin
         wr_in = wr_ff + 1'b1;
      end
      if (cmd.pull && !empty) begin
         rd_in = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= CNT_W'(2);
         fmt_ff <= FMT_INT16;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         fmt_ff <= fmt_in;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         mem[wr_ff] <= {req_right_sample, req_left_sample};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pull) begin
         rdata_ff <= mem[rd_ff];
      end
   end

   // pull bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.pull) begin
         under_ff   <= empty;
         free_ff    <= empty ? FREE_W'(free_now) : FREE_W'(free_now + 1'b1);
         last_ch_ff <= last_ch;
      end
   end

   // converter stage 1: magnitude, scaling product, leading one
   assign raw = under_ff ? '0 : (cmd.sel_right ? rdata_ff[63:32] : rdata_ff[31:0]);
   assign neg = raw[SAMPLE_W-1];
   assign mag = neg ? (SAMPLE_W'(0) - raw) : raw;

   always_comb begin
      case (fmt_ff)
         FMT_INT16: scale = SCALE_INT16;
         FMT_INT24: scale = SCALE_INT24;
         FMT_INT32: scale = SCALE_INT32;
         default:   scale = '0;
      endcase
   end

   always_comb begin
      top = '0;
      for (int i = 0; i < SAMPLE_W; i++) begin
         if (mag[i]) begin
            top = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_neg_ff  <= neg;
      s1_mag_ff  <= mag;
      s1_prod_ff <= {31'd0, mag} * {32'd0, scale};
      s1_top_ff  <= top;
   end

   // converter stage 2: saturate, normalize, round
   assign q     = s1_prod_ff[62:28];
   assign q_lim = {4'd0, scale} + {34'd0, s1_neg_ff};
   assign q_sat = (q > q_lim) ? q_lim : q;
   assign int_word = s1_neg_ff ? (WORD_W'(0) - {29'd0, q_sat}) : {29'd0, q_sat};

   assign norm  = s1_mag_ff << (5'd31 - s1_top_ff);
   assign rnd   = norm[7] && ((|norm[6:0]) || norm[8]);
   assign rsum  = {1'b0, norm[31:8]} + {24'd0, rnd};
   assign exp8  = {3'd0, s1_top_ff} + F32_BIAS_Q + {7'd0, rsum[24]};
   assign exp11 = {6'd0, s1_top_ff} + F64_BIAS_Q;

   always_comb begin
      conv_word = '0;
      case (fmt_ff)
         FMT_INT16, FMT_INT24, FMT_INT32: conv_word = int_word;
         FMT_FLOAT32: begin
            if (s1_mag_ff != '0) begin
               conv_word = {32'd0, s1_neg_ff, exp8, rsum[22:0]};
            end
         end
         FMT_FLOAT64: begin
            if (s1_mag_ff != '0) begin
               conv_word = {s1_neg_ff, exp11, norm[30:0], 21'd0};
            end
         end
         default: conv_word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_l) begin
         conv_l_ff <= conv_word;
      end
      if (cmd.cap_r) begin
         conv_r_ff <= conv_word;
      end
   end

   // result register
   always_comb begin
      case (ch_ff)
         CH_W'(0): emit_word = conv_l_ff;
         CH_W'(1): emit_word = conv_r_ff;
         default:  emit_word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.pull) begin
         ch_ff <= '0;
      end else if (cmd.emit) begin
         ch_ff <= ch_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_accepted    <= !full;
         rsp_frames_free <= full ? '0 : FREE_W'(free_now - 1'b1);
         rsp_channel     <= '0;
         rsp_sample_word <= '0;
         rsp_underrun    <= 1'b0;
         rsp_last        <= 1'b1;
      end else if (cmd.emit) begin
         rsp_accepted    <= 1'b0;
         rsp_frames_free <= free_ff;
         rsp_channel     <= ch_ff;
         rsp_sample_word <= emit_word;
         rsp_underrun    <= under_ff;
         rsp_last        <= status.ch_last;
      end
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && full) |=> wr_ff == $past(wr_ff))
      else $error("write index moved on a full ring");

   a_underrun_holds_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.pull && empty) |=> rd_ff == $past(rd_ff))
      else $error("read index moved on underrun");

   a_never_overfill: assert property (@(posedge clock) disable iff (reset)
      used != ADDR_W'(RING_FRAMES - 1) || !(cmd.push) || full)
      else $error("occupancy and full flag disagree");

endmodule

FILE: rtl/core/stereo_fifo_output_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_fifo_output_format_converter
// Stereo frame ring feeding a per-channel PCM / float output converter.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// req      in         req_valid/ready    func, left_sample, right_sample
// rsp      out        rsp_valid/ready    accepted, frames_free, channel,
//                                        sample_word, underrun, last
// csr      in/out     APB psel/penable   channel_count, sample_format
//
// Push: one result per item.
// Pull: one store read, then the two-stage converter runs on left and right in
//   turn, then one channel result per cycle from the result register while
//   rsp_ready does not stall it; N results in all, N = clamped channel count.
// Reset clears the ring indices, config registers and sequencer state; the frame store is not cleared.
// A stalled rsp_ready holds the result register and blocks further items.
// ----------------------------------------------------------------------------
module stereo_fifo_output_format_converter import sfoc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic signed [31:0]     req_left_sample,
   input  logic signed [31:0]     req_right_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic [FREE_W-1:0]      rsp_frames_free,
   output logic [CH_W-1:0]        rsp_channel,
   output logic [WORD_W-1:0]      rsp_sample_word,
   output logic                   rsp_underrun,
   output logic                   rsp_last,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   sfoc_cmd_type    cmd;
   sfoc_status_type status;

   assign csr_pready = 1'b1;

   sfoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sfoc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_accepted     (rsp_accepted),
      .rsp_frames_free  (rsp_frames_free),
      .rsp_channel      (rsp_channel),
      .rsp_sample_word  (rsp_sample_word),
      .rsp_underrun     (rsp_underrun),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata)
   );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo FIFO output format converter. Frames are
// pushed and pulled over the req channel while a local model of the ring and
// of the PCM / float conversion predicts every rsp item; the rsp side compares
// each accepted item field by field against the oldest prediction. Channel
// count and sample format are set and read back over the APB port while the
// block is idle. Covers underrun, channel count clamping, all output formats
// including the unused codes, and random traffic under three handshake idling
// profiles.
// ----------------------------------------------------------------------------
module tb_top;
   import sfoc_pkg::*;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_PULL = 1'b1;
   localparam logic [FMT_W-1:0] FMT_UNUSED_HI = 3'd7;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_PRINTED = 50;
   localparam int ITEMS_PER_SETTING = 11;

   typedef struct packed {
      logic              accepted;
      logic [FREE_W-1:0] frames_free;
      logic [CH_W-1:0]   channel;
      logic [WORD_W-1:0] sample_word;
      logic              underrun;
      logic              last;
   } sample_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_func = FUNC_PUSH;
   logic [31:0]           req_left_sample = '0;
   logic [31:0]           req_right_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_accepted;
   logic [FREE_W-1:0]     rsp_frames_free;
   logic [CH_W-1:0]       rsp_channel;
   logic [WORD_W-1:0]     rsp_sample_word;
   logic                  rsp_underrun;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // ring and register image
   logic [63:0]       ring_mem [0:RING_FRAMES-1];
   logic [FREE_W-1:0] wr_ptr = '0;
   logic [FREE_W-1:0] rd_ptr = '0;
   logic [CNT_W-1:0]  cfg_channels = CNT_W'(2);
   logic [FMT_W-1:0]  cfg_format = FMT_INT16;

   sample_out_type pending_outputs [$];
   int             mismatch_count = 0;
   int             req_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             quiet_cycles = 0;
   bit             valid_up = 0;

   stereo_fifo_output_format_converter dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns ERROR %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // --------------------------------------------------------------------------
   // conversion model
   // --------------------------------------------------------------------------
   function automatic int msb_pos(input logic [31:0] mag);
      int p;
      p = 0;
      for (int i = 0; i < 32; i++)
         if (mag[i]) p = i;
      return p;
   endfunction

   function automatic logic [63:0] int_word(input logic neg, input logic [31:0] mag,
                                            input int bits);
      logic [63:0] scale;
      logic [63:0] q;
      scale = (64'd1 << (bits - 1)) - 64'd1;
      q = ({32'b0, mag} * scale) >> 28;
      if (neg) begin
         if (q > scale + 64'd1) q = scale + 64'd1;
         return -q;
      end
      if (q > scale) q = scale;
      return q;
   endfunction

   function automatic logic [63:0] f32_word(input logic neg, input logic [31:0] mag);
      int          p;
      int          s;
      logic [7:0]  e;
      logic [31:0] r;
      logic [31:0] rem;
      logic [31:0] half;
      if (mag == 0) return '0;
      p = msb_pos(mag);
      e = 8'(p) + F32_BIAS_Q;
      if (p <= 23) begin
         r = mag << (23 - p);
      end else begin
         s = p - 23;
         rem = mag & ((32'd1 << s) - 32'd1);
         half = 32'd1 << (s - 1);
         r = mag >> s;
         if (rem > half || (rem == half && r[0])) r = r + 32'd1;
         if (r == 32'h0100_0000) begin
            r = r >> 1;
            e = e + 8'd1;
         end
      end
      return {32'b0, neg, e, r[22:0]};
   endfunction

   function automatic logic [63:0] f64_word(input logic neg, input logic [31:0] mag);
      int          p;
      logic [10:0] e;
      logic [63:0] mant;
      if (mag == 0) return '0;
      p = msb_pos(mag);
      e = 11'(p) + F64_BIAS_Q;
      mant = {32'b0, mag} << (52 - p);
      return {neg, e, mant[51:0]};
   endfunction

   function automatic logic [63:0] pcm_word(input logic [31:0] raw);
      logic        neg;
      logic [31:0] mag;
      neg = raw[31];
      mag = neg ? -raw : raw;
      case (cfg_format)
         FMT_INT16:   return int_word(neg, mag, 16);
         FMT_INT24:   return int_word(neg, mag, 24);
         FMT_INT32:   return int_word(neg, mag, 32);
         FMT_FLOAT32: return f32_word(neg, mag);
         FMT_FLOAT64: return f64_word(neg, mag);
         default:     return '0;
      endcase
   endfunction

   function automatic logic [FREE_W-1:0] ring_free();
      logic [FREE_W-1:0] used;
      used = wr_ptr - rd_ptr;
      return FREE_W'(RING_FRAMES - 1) - used;
   endfunction

   function automatic void ring_predict(input logic func, input logic [31:0] left,
                                        input logic [31:0] right);
      sample_out_type    o;
      logic [63:0]       frame;
      logic              under;
      logic [FREE_W-1:0] fr;
      logic [31:0]       raw;
      int                n;
      o = '0;
      if (func == FUNC_PUSH) begin
         if (ring_free() != 0) begin
            ring_mem[wr_ptr] = {right, left};
            wr_ptr = wr_ptr + 1'b1;
            o.accepted = 1'b1;
         end
         o.frames_free = ring_free();
         o.last = 1'b1;
         pending_outputs.push_back(o);
         return;
      end
      frame = '0;
      under = 1'b0;
      if (rd_ptr != wr_ptr) begin
         frame = ring_mem[rd_ptr];
         rd_ptr = rd_ptr + 1'b1;
      end else begin
         under = 1'b1;
      end
      fr = ring_free();
      n = int'(cfg_channels);
      if (n < 1) n = 1;
      if (n > MAX_CHANNELS) n = MAX_CHANNELS;
      for (int ch = 0; ch < n; ch++) begin
         raw = (ch == 0) ? frame[31:0] : (ch == 1) ? frame[63:32] : 32'b0;
         o = '0;
         o.frames_free = fr;
         o.channel = CH_W'(ch);
         o.sample_word = pcm_word(raw);
         o.underrun = under;
         o.last = (ch == n - 1);
         pending_outputs.push_back(o);
      end
   endfunction

   // --------------------------------------------------------------------------
   // result checker and watchdog
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : check_outputs
      sample_out_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected rsp item channel %0d", rsp_channel));
         end else begin
            due = pending_outputs.pop_front();
            check_field("accepted", 64'(rsp_accepted), 64'(due.accepted));
            check_field("frames_free", 64'(rsp_frames_free), 64'(due.frames_free));
            check_field("channel", 64'(rsp_channel), 64'(due.channel));
            check_field("sample_word", rsp_sample_word, due.sample_word);
            check_field("underrun", 64'(rsp_underrun), 64'(due.underrun));
            check_field("last", 64'(rsp_last), 64'(due.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------
   task automatic send_item(input logic func, input logic [31:0] left,
                            input logic [31:0] right);
      req_func <= func;
      req_left_sample <= left;
      req_right_sample <= right;
      req_valid <= 1'b1;
      valid_up = 1;
      do @(posedge clock); while (!req_ready);
      ring_predict(func, left, right);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         valid_up = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic settle_outputs();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 0;
      end
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_set(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_CHANNEL_COUNT) begin
         cfg_channels = value[CNT_W-1:0];
         want = CSR_DATA_W'(cfg_channels);
      end else begin
         cfg_format = value[FMT_W-1:0];
         want = CSR_DATA_W'(cfg_format);
      end
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_field("csr readback", 64'(csr_prdata), 64'(want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2: v = 32'h0000_0000;
         3: v = $urandom_range(0, 1) ? 32'h1000_0000 : 32'hF000_0000;
         4: v = $urandom_range(0, 1) ? $urandom_range(1, 255) : -$urandom_range(1, 255);
         5: v = {8'($urandom_range(0, 255)), 24'h00_0080} | ($urandom & 32'hFFFF_FF00);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------
   task automatic test_underrun();
      send_item(FUNC_PULL, '0, '0);
      send_item(FUNC_PUSH, 32'h1000_0000, 32'hF000_0000);
      send_item(FUNC_PULL, '0, '0);
      send_item(FUNC_PULL, '0, '0);
      settle_outputs();
   endtask

   task automatic test_formats();
      for (int f = FMT_INT16; f <= FMT_UNUSED_HI; f++) begin
         csr_set(REG_SAMPLE_FORMAT, CSR_DATA_W'(f));
         send_item(FUNC_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
         if (f == FMT_FLOAT32) send_item(FUNC_PUSH, 32'h7FFF_FFC0, 32'hFFFF_FF01);
         send_item(FUNC_PULL, '0, '0);
         if (f == FMT_FLOAT32) send_item(FUNC_PULL, '0, '0);
         settle_outputs();
      end
   endtask

   task automatic test_channel_clamp();
      logic [CNT_W-1:0] counts [5];
      counts = '{CNT_W'(0), CNT_W'(1), CNT_W'(MAX_CHANNELS), CNT_W'(MAX_CHANNELS + 1),
                 CNT_W'(63)};
      csr_set(REG_SAMPLE_FORMAT, CSR_DATA_W'(FMT_INT24));
      foreach (counts[i]) begin
         csr_set(REG_CHANNEL_COUNT, CSR_DATA_W'(counts[i]));
         send_item(FUNC_PUSH, pick_sample(), pick_sample());
         send_item(FUNC_PULL, '0, '0);
         settle_outputs();
      end
   endtask

   task automatic test_random_traffic();
      logic [CNT_W-1:0] counts [7];
      counts = '{CNT_W'(0), CNT_W'(1), CNT_W'(2), CNT_W'(3), CNT_W'(MAX_CHANNELS),
                 CNT_W'(MAX_CHANNELS + 1), CNT_W'(63)};
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 55 : 0;
         rsp_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 19 : 0;
         for (int seg = 0; seg < 2; seg++) begin
            settle_outputs();
            if (seg == 0)
               csr_set(REG_CHANNEL_COUNT, CSR_DATA_W'(counts[$urandom_range(0, 6)]));
            else
               csr_set(REG_CHANNEL_COUNT, CSR_DATA_W'($urandom_range(0, 63)));
            csr_set(REG_SAMPLE_FORMAT, CSR_DATA_W'($urandom_range(FMT_INT16, FMT_UNUSED_HI)));
            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
               if ($urandom_range(0, 99) < 55)
                  send_item(FUNC_PUSH, pick_sample(), pick_sample());
               else
                  send_item(FUNC_PULL, $urandom, $urandom);
            end
         end
      end
      settle_outputs();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 19;
      rsp_stall_pct = 55;
      test_underrun();
      test_formats();
      test_channel_clamp();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outputs.size() != 0)
         report_mismatch($sformatf("%0d rsp items never arrived", pending_outputs.size()));
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: stereo_fifo_output_format_converter.f
rtl/core/sfoc_pkg.sv
rtl/core/sfoc_ctrl.sv
rtl/core/sfoc_dp.sv
rtl/core/stereo_fifo_output_format_converter.sv
dv/tb_top.sv
